// ===== design/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list store: operation and
// status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

	// Operation codes carried on the input tuser
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INSERT_AT  = 3'd2,
		OP_READ_ALL   = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_POP_BACK   = 3'd5,
		OP_DEL_MID    = 3'd6,
		OP_DEL_AT     = 3'd7
	} op_t;

	// Result status codes carried on the output tuser
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADLOC = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture the input beat
		logic exec;   // apply the edit and post the single result
		logic emit;   // post the front element and rotate the chain
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;      // output register can take a beat this cycle
		logic read_nonempty; // captured op is a read-all on a non-empty list
		logic rd_last;       // the element being emitted is the final one
	} sts_t;

endpackage

`default_nettype wire

// ===== design/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl
// Controller for the positional list store: sequences capture, execute and
// the element-by-element read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl import pls_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					if (sts.read_nonempty) begin
						state_d = S_READ;
					end else begin
						cmd.exec = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/pls_dpath.sv =====
// ----------------------------------------------------------------------------
// pls_dpath
// Datapath for the positional list store: captured operation, element count,
// a chain of element cells that shifts in one step on an edit or rotates one
// place per emitted beat, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_dpath import pls_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic [2:0]         in_op,
	input  wire logic signed [31:0] in_value,
	input  wire logic [7:0]         in_loc,
	output logic signed [31:0]      out_element,
	output logic [1:0]              out_status,
	output logic                    out_last,
	output logic [6:0]              out_count,
	output logic                    out_valid,
	input  wire logic               out_ready
);

	op_t                op_q;
	logic signed [31:0] value_q;
	logic [7:0]         loc_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_idx_q;
	logic signed [31:0] cells_q [DEPTH];
	logic signed [31:0] prev_c  [DEPTH];
	logic signed [31:0] next_c  [DEPTH];

	logic [CW-1:0] count_m1;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx;
	logic [7:0]    count8;
	logic          full;
	logic          empty;
	logic          do_ins;
	logic          do_del;
	status_t       st;
	logic          out_free;

	logic signed [31:0] elem_q;
	status_t            status_q;
	logic               last_q;
	logic [6:0]         ocount_q;
	logic               valid_q;

	assign count_m1 = count_q - CW'(1);
	assign count8   = 8'(count_q);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(in_op);
			value_q <= in_value;
			loc_q   <= in_loc;
		end
	end

	// Decode the operation into an edit, a target index and a status
	always_comb begin
		st     = ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		idx    = '0;
		case (op_q)
			OP_PUSH_FRONT: begin
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = count_q;
				end
			end
			OP_INSERT_AT: begin
				if (full) begin
					st = ST_FULL;
				end else if (loc_q > count8) begin
					st = ST_BADLOC;
				end else begin
					do_ins = 1'b1;
					if (empty) idx = '0;
					else if (loc_q == 8'd0) idx = CW'(1);
					else idx = CW'(loc_q);
				end
			end
			OP_READ_ALL: begin
				if (empty) st = ST_EMPTY;
			end
			OP_POP_FRONT: begin
				if (empty) st = ST_EMPTY;
				else do_del = 1'b1;
			end
			OP_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_del = 1'b1;
					idx    = count_m1;
				end
			end
			OP_DEL_MID: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_del = 1'b1;
					idx    = count_m1 >> 1;
				end
			end
			OP_DEL_AT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (loc_q == 8'd0 || loc_q >= count8) begin
					st = ST_BADLOC;
				end else begin
					do_del = 1'b1;
					idx    = CW'(loc_q);
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign count_d = do_ins ? count_q + CW'(1) : (do_del ? count_m1 : count_q);

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// Neighbor taps of the cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_tap
		if (i == 0) begin : g_first
			assign prev_c[i] = value_q;
		end else begin : g_prev
			assign prev_c[i] = cells_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign next_c[i] = cells_q[i];
		end else begin : g_next
			assign next_c[i] = cells_q[i+1];
		end
	end

	// Cell chain: shift up on insert, down on delete, rotate on emit
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] Pos = CW'(i);
		always_ff @(posedge clk) begin
			if (cmd.exec && do_ins && Pos >= idx) begin
				cells_q[i] <= (Pos == idx) ? value_q : prev_c[i];
			end else if (cmd.exec && do_del && Pos >= idx) begin
				cells_q[i] <= next_c[i];
			end else if (cmd.emit && Pos < count_q) begin
				cells_q[i] <= (Pos == count_m1) ? cells_q[0] : next_c[i];
			end
		end
	end

	// Read-out position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.load) begin
			rd_idx_q <= '0;
		end else if (cmd.emit) begin
			rd_idx_q <= rd_idx_q + CW'(1);
		end
	end

	// Output register: hold until taken
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.exec || cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			elem_q   <= '0;
			status_q <= st;
			last_q   <= 1'b1;
			ocount_q <= 7'(count_d);
		end else if (cmd.emit) begin
			elem_q   <= cells_q[0];
			status_q <= ST_OK;
			last_q   <= (rd_idx_q == count_m1);
			ocount_q <= 7'(count_q);
		end
	end

	assign sts.out_free      = out_free;
	assign sts.read_nonempty = (op_q == OP_READ_ALL) && !empty;
	assign sts.rd_last       = (rd_idx_q == count_m1);

	assign out_element = elem_q;
	assign out_status  = status_q;
	assign out_last    = last_q;
	assign out_count   = ocount_q;
	assign out_valid   = valid_q;

endmodule

`default_nettype wire

// ===== design/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to DEPTH signed 32-bit values with positional insert,
// delete and a full read-out.
// ----------------------------------------------------------------------------
// Each input beat carries one operation. An edit or a status-only operation
// is captured, then applied once the output register is free: the element
// chain shifts in a single step and the result beat is posted. A read-all is
// captured, the controller turns to the read-out, and the elements are
// emitted one per cycle while the output register is free, since the chain
// rotates one place per emitted beat and the front cell feeds the output
// register. The output register holds a result while the next beat is
// captured; a new beat is taken only once the previous operation has posted
// its last beat. Errors (empty list, bad location, full list) leave the list
// unchanged and are reported in the status with a single result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store import pls_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // value[31:0], location[39:32]
	input  wire logic [2:0]  s_tuser,  // operation[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // element[31:0], count[38:32], zero[39]
	output logic [1:0]       m_tuser,  // status[1:0]
	output logic             m_tlast
);

	localparam int CW = $clog2(DEPTH + 1);

	cmd_t               cmd;
	sts_t               sts;
	logic signed [31:0] element;
	logic [6:0]         count;

	// Sequence capture, execute and read-out
	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the list and the output beat
	pls_dpath #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (s_tuser),
		.in_value    (s_tdata[31:0]),
		.in_loc      (s_tdata[39:32]),
		.out_element (element),
		.out_status  (m_tuser),
		.out_last    (m_tlast),
		.out_count   (count),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready)
	);

	assign m_tdata = {1'b0, count, element};

	// Count never exceeds the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[38:32] <= 7'(DEPTH)))
		else $error("result count above capacity");

	// A full report only comes with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[38:32] == 7'(DEPTH)))
		else $error("full status with list not full");

	// An empty report only comes with an empty list and a zero element
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[38:0] == '0))
		else $error("empty status with elements held");

	// Only read-out beats are non-final, and they are always ok
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == ST_OK && !s_tready))
		else $error("non-final beat outside a read-out");

endmodule

`default_nettype wire

// ===== tb/positional_list_store_test.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_test
// Self-checking bench for the positional list store. A behavioral list
// model predicts every result beat of each accepted operation. Directed
// runs cover the empty list, edge locations and the full list. Random
// traffic then fills and drains the list under changing backpressure.
// ----------------------------------------------------------------------------
module positional_list_store_test;
	import pls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 16;

	typedef struct {
		logic [31:0] element;
		status_t     status;
		logic        last;
		logic [6:0]  count;
	} list_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // value[31:0], location[39:32]
	logic [2:0]  s_tuser;  // operation[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // element[31:0], count[38:32], zero[39]
	logic [1:0]  m_tuser;  // status[1:0]
	logic        m_tlast;

	// Shadow copy of the list and the beats it says must come out
	logic [31:0] shadow_list [LIST_DEPTH];
	int          shadow_len;
	list_beat_t  pending_beats [$];

	int mismatch_count;
	int src_idle_pct;
	int sink_idle_pct;
	bit filling;

	positional_list_store #(.DEPTH(LIST_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Queue one single-beat result carrying the current length
	function automatic void post_status(status_t st);
		list_beat_t beat;
		beat.element = '0;
		beat.status  = st;
		beat.last    = 1'b1;
		beat.count   = shadow_len[6:0];
		pending_beats.push_back(beat);
	endfunction

	// Apply one operation to the shadow list and queue its result beats
	function automatic void predict_list_op(op_t op, logic [31:0] value, logic [7:0] loc);
		list_beat_t beat;
		status_t    st;
		bit         do_ins;
		bit         do_del;
		int         idx;

		st = ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		idx = 0;
		case (op)
			OP_PUSH_FRONT: begin
				do_ins = 1'b1;
				idx = 0;
			end
			OP_PUSH_BACK: begin
				do_ins = 1'b1;
				idx = shadow_len;
			end
			OP_INSERT_AT: begin
				if (shadow_len >= LIST_DEPTH) st = ST_FULL;
				else if (int'(loc) > shadow_len) st = ST_BADLOC;
				else begin
					do_ins = 1'b1;
					idx = (shadow_len == 0) ? 0 : ((loc == 0) ? 1 : int'(loc));
				end
			end
			OP_READ_ALL: begin
				if (shadow_len == 0) post_status(ST_EMPTY);
				for (int i = 0; i < shadow_len; i++) begin
					beat.element = shadow_list[i];
					beat.status  = ST_OK;
					beat.last    = (i == shadow_len - 1);
					beat.count   = shadow_len[6:0];
					pending_beats.push_back(beat);
				end
				return;
			end
			OP_POP_FRONT: begin
				do_del = 1'b1;
				idx = 0;
			end
			OP_POP_BACK: begin
				do_del = 1'b1;
				idx = shadow_len - 1;
			end
			OP_DEL_MID: begin
				do_del = 1'b1;
				idx = (shadow_len - 1) / 2;
			end
			default: begin
				if (shadow_len == 0) st = ST_EMPTY;
				else if (loc == 0 || int'(loc) >= shadow_len) st = ST_BADLOC;
				else begin
					do_del = 1'b1;
					idx = int'(loc);
				end
			end
		endcase

		// Shift the tail up to open a slot
		if (do_ins) begin
			if (shadow_len >= LIST_DEPTH) st = ST_FULL;
			else begin
				for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i - 1];
				shadow_list[idx] = value;
				shadow_len++;
			end
		end

		// Shift the tail down over the removed slot
		if (do_del) begin
			if (shadow_len == 0) st = ST_EMPTY;
			else begin
				for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
				shadow_len--;
			end
		end
		post_status(st);
	endfunction

	// Drive one beat into the slave side and predict it once accepted
	task automatic send_item(op_t op, logic [31:0] value, logic [7:0] loc);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {loc, value};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predict_list_op(op, value, loc);
		@(negedge clk);
	endtask

	// Toggle ready on the master side
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin : check_beats
		list_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected beat element=%h count=%0d status=%0d last=%b",
						$realtime, m_tdata[31:0], m_tdata[38:32], m_tuser, m_tlast);
			end else begin
				want = pending_beats.pop_front();
				if (m_tdata[31:0] !== want.element || m_tdata[38:32] !== want.count ||
				    m_tuser !== want.status || m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$write("%0t: beat mismatch exp element=%h count=%0d status=%0d last=%b, ",
							$realtime, want.element, want.count, want.status, want.last);
						$display("got element=%h count=%0d status=%0d last=%b",
							m_tdata[31:0], m_tdata[38:32], m_tuser, m_tlast);
					end
				end
			end
		end
	end

	// Operations on an empty list and the first single element
	task automatic test_empty_list();
		send_item(OP_READ_ALL, 32'd0, 8'd0);
		send_item(OP_POP_FRONT, 32'd0, 8'd0);
		send_item(OP_POP_BACK, 32'd0, 8'd0);
		send_item(OP_DEL_MID, 32'd0, 8'd0);
		send_item(OP_DEL_AT, 32'd0, 8'd1);
		send_item(OP_INSERT_AT, 32'h1234_5678, 8'd3);
		send_item(OP_INSERT_AT, 32'h8000_0000, 8'd0);
		send_item(OP_DEL_AT, 32'd0, 8'd0);
		send_item(OP_POP_BACK, 32'd0, 8'd0);
	endtask

	// Edge locations for insert and delete
	task automatic test_locations();
		send_item(OP_PUSH_BACK, 32'h7fff_ffff, 8'd0);
		send_item(OP_PUSH_FRONT, 32'h0000_0000, 8'd0);
		send_item(OP_INSERT_AT, 32'hffff_ffff, 8'd0);
		send_item(OP_INSERT_AT, 32'h5a5a_a5a5, 8'd3);
		send_item(OP_INSERT_AT, 32'h0bad_0bad, 8'd255);
		send_item(OP_DEL_AT, 32'd0, 8'd4);
		send_item(OP_DEL_AT, 32'd0, 8'd255);
		send_item(OP_READ_ALL, 32'd0, 8'd0);
		send_item(OP_DEL_AT, 32'd0, 8'd2);
		send_item(OP_DEL_MID, 32'd0, 8'd0);
		send_item(OP_READ_ALL, 32'd0, 8'd0);
	endtask

	// Fill to capacity, bounce inserts off the full list, read it out and delete from it
	task automatic test_full_list();
		while (shadow_len < LIST_DEPTH) send_item(OP_PUSH_BACK, $urandom, 8'd0);
		send_item(OP_PUSH_FRONT, 32'h1111_1111, 8'd0);
		send_item(OP_PUSH_BACK, 32'h2222_2222, 8'd0);
		send_item(OP_INSERT_AT, 32'h3333_3333, 8'd1);
		send_item(OP_READ_ALL, 32'd0, 8'd0);
		send_item(OP_DEL_MID, 32'd0, 8'd0);
		send_item(OP_DEL_AT, 32'd0, 8'(LIST_DEPTH - 2));
		send_item(OP_POP_FRONT, 32'd0, 8'd0);
	endtask

	// Random traffic that swings the list between empty and full
	task automatic test_random_traffic(int n_items);
		op_t         op;
		logic [31:0] value;
		logic [7:0]  loc;
		int          pick;
		int          ins_pct;

		for (int n = 0; n < n_items; n++) begin
			if (shadow_len == LIST_DEPTH) filling = 1'b0;
			else if (shadow_len == 0) filling = 1'b1;
			else if ($urandom_range(99) < 3) filling = !filling;
			ins_pct = filling ? 65 : 20;

			pick = $urandom_range(99);
			if (pick < ins_pct) begin
				case ($urandom_range(2))
					0: op = OP_PUSH_FRONT;
					1: op = OP_PUSH_BACK;
					default: op = OP_INSERT_AT;
				endcase
			end else if (pick < ins_pct + 10) begin
				op = OP_READ_ALL;
			end else begin
				case ($urandom_range(3))
					0: op = OP_POP_FRONT;
					1: op = OP_POP_BACK;
					2: op = OP_DEL_MID;
					default: op = OP_DEL_AT;
				endcase
			end

			case ($urandom_range(9))
				0: value = 32'h8000_0000;
				1: value = 32'h7fff_ffff;
				default: value = $urandom;
			endcase

			if ($urandom_range(99) < 70) loc = 8'($urandom_range(shadow_len + 1));
			else loc = 8'($urandom_range(255));

			send_item(op, value, loc);
		end
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		shadow_len = 0;
		mismatch_count = 0;
		filling = 1'b1;
		src_idle_pct = 25;
		sink_idle_pct = 79;
		for (int i = 0; i < LIST_DEPTH; i++) shadow_list[i] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_locations();
		test_full_list();
		test_random_traffic(150);

		src_idle_pct = 79;
		sink_idle_pct = 25;
		test_random_traffic(150);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_traffic(150);

		// Drop valid, drain outstanding beats, then watch for strays
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
